// ===== rtl/bracket_balance_checker_assert.svh =====
// assertion macros used by bracket_balance_checker.sv
`ifndef BRACKET_BALANCE_CHECKER_ASSERT_SVH
`define BRACKET_BALANCE_CHECKER_ASSERT_SVH

// same-cycle implication, sampled on clk, off while rst is high
`define BBC_ASSERT_NOW(name, pre, post) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("bbc assertion failed");

// next-cycle implication, sampled on clk, off while rst is high
`define BBC_ASSERT_NEXT(name, pre, post) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("bbc assertion failed");

`endif

// ===== rtl/bbc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package bbc_pkg;

  typedef struct packed {
    logic [1:0]  btype;
    logic [15:0] line;
    logic [11:0] column;
  } token_t;

  typedef enum logic [1:0] {
    SHIFT_HOLD,
    SHIFT_DOWN,
    SHIFT_UP
  } shift_op_t;

  localparam logic [1:0] ACT_OPEN  = 2'd0;
  localparam logic [1:0] ACT_CLOSE = 2'd1;
  localparam logic [1:0] ACT_END   = 2'd2;

  localparam logic [2:0] KIND_UNMATCHED = 3'd0;
  localparam logic [2:0] KIND_MISMATCH  = 3'd1;
  localparam logic [2:0] KIND_UNCLOSED  = 3'd2;
  localparam logic [2:0] KIND_OVERFLOW  = 3'd3;
  localparam logic [2:0] KIND_SUMMARY   = 3'd4;

endpackage

`default_nettype wire

// ===== rtl/bbc_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none

module bbc_cell (
  input  wire                clk,
  input  bbc_pkg::shift_op_t op,
  input  bbc_pkg::token_t    from_prev,
  input  bbc_pkg::token_t    from_next,
  output bbc_pkg::token_t    q
);
  import bbc_pkg::*;

  token_t entry;

  always_ff @(posedge clk) begin
    case (op)
      SHIFT_DOWN: entry <= from_prev;
      SHIFT_UP:   entry <= from_next;
      default:    entry <= entry;
    endcase
  end

  assign q = entry;

endmodule

`default_nettype wire

// ===== rtl/bbc_chain.sv =====
`timescale 1ns / 1ps
`default_nettype none

module bbc_chain #(
  parameter int STACK_DEPTH = 32
) (
  input  wire                clk,
  input  bbc_pkg::shift_op_t op,
  input  bbc_pkg::token_t    push_in,
  output bbc_pkg::token_t    top,
  output bbc_pkg::token_t    bottom
);
  import bbc_pkg::*;

  token_t q [STACK_DEPTH];

  // cell 0 is the top of stack; down moves entries toward the far end
  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    token_t prev_v;
    token_t next_v;
    if (i == 0) begin : g_first
      assign prev_v = push_in;
    end else begin : g_prev
      assign prev_v = q[i-1];
    end
    if (i == STACK_DEPTH - 1) begin : g_last
      assign next_v = '0;
    end else begin : g_next
      assign next_v = q[i+1];
    end
    bbc_cell u_cell (
      .clk       (clk),
      .op        (op),
      .from_prev (prev_v),
      .from_next (next_v),
      .q         (q[i])
    );
  end

  assign top    = q[0];
  assign bottom = q[STACK_DEPTH-1];

endmodule

`default_nettype wire

// ===== rtl/bracket_balance_checker.sv =====
// bracket balance checker
// input channel: in_valid / in_stall with action, bracket_type, line_number,
// column_number; one bracket token per item.
// output channel: out_valid / out_stall with offence_kind, first_*, second_*,
// all_clear and last; last marks the final result of an input item.
// open and close tokens are taken one per cycle while in_stall is low; a result,
// if any, passes through the res and outq registers to the output.
// end of stream walks the row of stack cells toward its far end: with n
// opens held it first shifts them down until the oldest sits in the far
// cell, then gives one result per leftover open (bottom first), then the
// summary; with an empty stack it gives only the summary. no item is taken
// meanwhile.
// two result registers sit before the port, so an item is still taken while
// one result waits on out_stall; when both are full, in_stall rises.
// rst (synchronous) empties the stack and clears the offence flag and all
// valids; stack contents are never read before they are written.
`timescale 1ns / 1ps
`default_nettype none

`include "bracket_balance_checker_assert.svh"

module bracket_balance_checker #(
  parameter int STACK_DEPTH = 32
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         in_valid,
  output logic        in_stall,
  input  wire  [1:0]  action,
  input  wire  [1:0]  bracket_type,
  input  wire  [15:0] line_number,
  input  wire  [11:0] column_number,
  output logic        out_valid,
  input  wire         out_stall,
  output logic [2:0]  offence_kind,
  output logic [1:0]  first_type,
  output logic [15:0] first_line,
  output logic [11:0] first_column,
  output logic [1:0]  second_type,
  output logic [15:0] second_line,
  output logic [11:0] second_column,
  output logic        all_clear,
  output logic        last
);
  import bbc_pkg::*;

  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(STACK_DEPTH);

  typedef enum logic {
    ST_TOKEN,
    ST_DRAIN
  } state_t;

  typedef struct packed {
    logic [2:0] kind;
    token_t     first;
    token_t     second;
    logic       clear;
    logic       fin;
  } result_t;

  state_t    state, state_next;
  logic [CW-1:0] count, count_next;
  logic [CW-1:0] gap, gap_next;
  logic      seen, seen_next;
  logic      res_valid;
  result_t   res, res_next;
  logic      res_load;
  result_t   outq;
  shift_op_t op;
  token_t    tok, top, bottom;
  logic      take, res_move, res_free;

  assign tok = '{btype: bracket_type, line: line_number, column: column_number};

  assign res_move = res_valid && (!out_valid || !out_stall);
  assign res_free = !res_valid || res_move;
  assign in_stall = (state == ST_DRAIN) || !res_free;
  assign take     = in_valid && !in_stall;

  bbc_chain #(.STACK_DEPTH(STACK_DEPTH)) u_chain (
    .clk     (clk),
    .op      (op),
    .push_in (tok),
    .top     (top),
    .bottom  (bottom)
  );

  always_comb begin
    state_next = state;
    count_next = count;
    gap_next   = gap;
    seen_next  = seen;
    op         = SHIFT_HOLD;
    res_load   = 1'b0;
    res_next   = '{kind: KIND_SUMMARY, first: '0, second: '0, clear: 1'b0, fin: 1'b1};
    case (state)
      ST_TOKEN: begin
        if (take) begin
          case (action)
            ACT_OPEN: begin
              if (count != DEPTH_C) begin
                op         = SHIFT_DOWN;
                count_next = count + 1'b1;
              end else begin
                res_load       = 1'b1;
                res_next.kind  = KIND_OVERFLOW;
                res_next.first = tok;
                seen_next      = 1'b1;
              end
            end
            ACT_CLOSE: begin
              if (count == '0) begin
                res_load       = 1'b1;
                res_next.kind  = KIND_UNMATCHED;
                res_next.first = tok;
                seen_next      = 1'b1;
              end else begin
                if (top.btype != bracket_type) begin
                  res_load        = 1'b1;
                  res_next.kind   = KIND_MISMATCH;
                  res_next.first  = top;
                  res_next.second = tok;
                  seen_next       = 1'b1;
                end
                op         = SHIFT_UP;
                count_next = count - 1'b1;
              end
            end
            ACT_END: begin
              state_next = ST_DRAIN;
              gap_next   = (count == '0) ? '0 : DEPTH_C - count;
            end
            default: begin
            end
          endcase
        end
      end
      ST_DRAIN: begin
        if (gap != '0) begin
          // slide the bottom entry out to the far cell
          op       = SHIFT_DOWN;
          gap_next = gap - 1'b1;
        end else if (count != '0) begin
          if (res_free) begin
            res_load       = 1'b1;
            res_next.kind  = KIND_UNCLOSED;
            res_next.first = bottom;
            res_next.fin   = 1'b0;
            seen_next      = 1'b1;
            op             = SHIFT_DOWN;
            count_next     = count - 1'b1;
          end
        end else if (res_free) begin
          res_load       = 1'b1;
          res_next.clear = !seen;
          seen_next      = 1'b0;
          state_next     = ST_TOKEN;
        end
      end
      default: begin
        state_next = ST_TOKEN;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_TOKEN;
      count     <= '0;
      gap       <= '0;
      seen      <= 1'b0;
      res_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      gap   <= gap_next;
      seen  <= seen_next;
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (res_move) begin
        res_valid <= 1'b0;
      end
      if (res_move) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
    if (res_load) begin
      res <= res_next;
    end
    if (res_move) begin
      outq <= res;
    end
  end

  assign offence_kind  = outq.kind;
  assign first_type    = outq.first.btype;
  assign first_line    = outq.first.line;
  assign first_column  = outq.first.column;
  assign second_type   = outq.second.btype;
  assign second_line   = outq.second.line;
  assign second_column = outq.second.column;
  assign all_clear     = outq.clear;
  assign last          = outq.fin;

  `BBC_ASSERT_NOW(a_count_bound, 1'b1, count <= DEPTH_C)
  `BBC_ASSERT_NEXT(a_drain_no_growth, state == ST_DRAIN, count <= $past(count))
  `BBC_ASSERT_NOW(a_gap_only_in_drain, gap != '0, state == ST_DRAIN)
  `BBC_ASSERT_NEXT(a_drain_exit_empty, state == ST_DRAIN && state_next == ST_TOKEN,
                   count == '0 && !seen)
  `BBC_ASSERT_NOW(a_summary_is_last, out_valid && offence_kind == KIND_SUMMARY, last)

endmodule

`default_nettype wire
